>>> hdl/edi_af_packet_tag_parser_top_defines.svh
// ----------------------------------------------------------------------------
// EDI AF tag parser assertion macros
// Clocked, reset-qualified assertion helpers for the parser top level.
// ----------------------------------------------------------------------------
`ifndef EDI_AF_PACKET_TAG_PARSER_TOP_DEFINES_SVH
`define EDI_AF_PACKET_TAG_PARSER_TOP_DEFINES_SVH

// Implication checked at every rising clk edge outside reset.
`define EDI_TP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Invariant checked at every rising clk edge outside reset.
`define EDI_TP_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

>>> hdl/edi_tp_pkg.sv
// ----------------------------------------------------------------------------
// EDI AF tag parser package
// Shared codes, types, constants and the CRC-16 byte update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package edi_tp_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [15:0] SYNC_AF  = 16'h4146;
    localparam logic [15:0] SYNC_PF  = 16'h5046;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [2:0]  MAJ_VER  = 3'd1;
    localparam logic [3:0]  MIN_VER  = 4'd0;
    localparam logic [7:0]  PT_TAG   = 8'h54;
    localparam logic [7:0]  STAT_OK  = 8'hFF;
    localparam logic [31:0] NAME_DETI = 32'h64657469;
    localparam logic [23:0] NAME_EST  = 24'h657374;
    localparam logic [7:0]  EST_MAX   = 8'd64;
    localparam logic [31:0] FIC_LONG  = 32'd128;
    localparam logic [31:0] FIC_SHORT = 32'd96;
    localparam logic [1:0]  MODE_3    = 2'd3;

    localparam logic [7:0] CFG_WANTED = 8'd0;
    localparam logic [7:0] CFG_ENABLE = 8'd1;

    typedef enum logic [1:0] {
        KIND_FIC     = 2'd0,
        KIND_STREAM  = 2'd1,
        KIND_VERDICT = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        V_OK       = 3'd0,
        V_PF       = 3'd1,
        V_BAD_SYNC = 3'd2,
        V_NO_CRC   = 3'd3,
        V_BAD_VER  = 3'd4,
        V_BAD_PT   = 3'd5,
        V_CRC_ERR  = 3'd6,
        V_LEN_ERR  = 3'd7
    } verdict_t;

    typedef enum logic [1:0] {
        ACT_IGNORE = 2'd0,
        ACT_DETI   = 2'd1,
        ACT_EST    = 2'd2
    } action_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       block_last;
        verdict_t   verdict;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t item;
    } push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (r[15])
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            else
                r = {r[14:0], 1'b0};
        end
        return r;
    endfunction

endpackage

>>> hdl/edi_tp_front.sv
// ----------------------------------------------------------------------------
// EDI AF tag parser front end
// Header check, CRC, TAG item walk; one classified result per byte at most.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edi_tp_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           frame_byte,
    input  logic                 frame_last,
    input  logic                 cfg_we,
    input  logic [7:0]           cfg_index,
    input  logic [7:0]           cfg_data,
    output edi_tp_pkg::push_t    push
);

    logic [31:0]          pos_reg, pos_next;
    logic [31:0]          plen_reg, plen_next;
    logic [15:0]          crc_reg, crc_next;
    logic [2:0]           herr_reg, herr_next;
    logic [31:0]          ipos_reg, ipos_next;
    logic [31:0]          iname_reg, iname_next;
    logic [31:0]          ibits_reg, ibits_next;
    logic [7:0]           iflags_reg, iflags_next;
    edi_tp_pkg::action_t  iact_reg, iact_next;
    logic [7:0]           crch_reg, crch_next;
    logic [5:0]           wanted_reg;
    logic                 enable_reg;

    logic [15:0]          sync;
    logic [32:0]          end_v;
    logic                 in_payload;
    logic                 walk_en;
    logic [31:0]          p;
    logic                 start;
    logic                 skip;
    logic [31:0]          name_w, bits_w;
    logic [7:0]           flags_w;
    edi_tp_pkg::action_t  act_w;
    logic [31:0]          v, nbytes, atst, rfud, lim, fic, req;
    logic [32:0]          total;
    logic [32:0]          bits_rnd;
    logic [31:0]          ipos_inc;
    logic                 emit;
    edi_tp_pkg::kind_t    kind;
    logic                 last;
    edi_tp_pkg::verdict_t code;

    always_comb
    begin
        plen_next = (pos_reg < 32'd6) ? {plen_reg[23:0], frame_byte} : plen_reg;
        herr_next = herr_reg;
        sync = {plen_reg[7:0], frame_byte};
        if (herr_reg == 3'(edi_tp_pkg::V_OK))
        begin
            if (pos_reg == 32'd1)
            begin
                if (sync == edi_tp_pkg::SYNC_PF)
                    herr_next = 3'(edi_tp_pkg::V_PF);
                else if (sync != edi_tp_pkg::SYNC_AF)
                    herr_next = 3'(edi_tp_pkg::V_BAD_SYNC);
            end
            else if (pos_reg == 32'd8)
            begin
                if (!frame_byte[7])
                    herr_next = 3'(edi_tp_pkg::V_NO_CRC);
                else if (frame_byte[6:4] != edi_tp_pkg::MAJ_VER
                         || frame_byte[3:0] != edi_tp_pkg::MIN_VER)
                    herr_next = 3'(edi_tp_pkg::V_BAD_VER);
            end
            else if (pos_reg == 32'd9)
            begin
                if (frame_byte != edi_tp_pkg::PT_TAG)
                    herr_next = 3'(edi_tp_pkg::V_BAD_PT);
            end
        end

        end_v      = 33'd10 + {1'b0, plen_next};
        in_payload = {1'b0, pos_reg} < end_v;
        crc_next   = in_payload ? edi_tp_pkg::crc_feed(crc_reg, frame_byte) : crc_reg;
        crch_next  = ({1'b0, pos_reg} == end_v) ? frame_byte : crch_reg;
        walk_en    = (pos_reg >= 32'd10) && in_payload
                     && (herr_reg == 3'(edi_tp_pkg::V_OK));

        p     = pos_reg - 32'd10;
        start = (ipos_reg == 32'd0);
        skip  = start && ((plen_next <= 32'd8) || (p >= plen_next - 32'd8));

        name_w  = start ? 32'd0 : iname_reg;
        bits_w  = start ? 32'd0 : ibits_reg;
        flags_w = start ? 8'd0 : iflags_reg;
        act_w   = start ? edi_tp_pkg::ACT_IGNORE : iact_reg;
        emit    = 1'b0;
        kind    = edi_tp_pkg::KIND_FIC;
        last    = 1'b0;
        v       = ipos_reg - 32'd8;
        nbytes  = {3'b000, bits_w[31:3]};
        atst    = flags_w[7] ? 32'd8 : 32'd0;
        rfud    = flags_w[5] ? 32'd3 : 32'd0;
        lim     = nbytes - rfud;
        fic     = 32'd0;
        req     = 32'd0;

        if (ipos_reg < 32'd4)
            name_w = {name_w[23:0], frame_byte};
        else if (ipos_reg < 32'd8)
        begin
            bits_w = {bits_w[23:0], frame_byte};
            if (ipos_reg == 32'd7)
            begin
                if (name_w == edi_tp_pkg::NAME_DETI)
                    act_w = edi_tp_pkg::ACT_DETI;
                else if (name_w[31:8] == edi_tp_pkg::NAME_EST && name_w[7:0] >= 8'd1
                         && name_w[7:0] <= edi_tp_pkg::EST_MAX && bits_w >= 32'd24)
                    act_w = edi_tp_pkg::ACT_EST;
            end
        end
        else if (act_w == edi_tp_pkg::ACT_DETI)
        begin
            if (v == 32'd0)
                flags_w = frame_byte;
            else if (v == 32'd2)
            begin
                if (frame_byte != edi_tp_pkg::STAT_OK)
                    act_w = edi_tp_pkg::ACT_IGNORE;
            end
            else if (v == 32'd3)
            begin
                if (flags_w[6])
                    fic = (frame_byte[7:6] == edi_tp_pkg::MODE_3)
                          ? edi_tp_pkg::FIC_LONG : edi_tp_pkg::FIC_SHORT;
                req = (32'd6 + atst + fic + rfud) << 3;
                if (fic == 32'd0 || bits_w != req)
                    act_w = edi_tp_pkg::ACT_IGNORE;
            end
            else if (v >= 32'd6 + atst && v < lim)
            begin
                emit = 1'b1;
                kind = edi_tp_pkg::KIND_FIC;
                last = (v == lim - 32'd1);
            end
        end
        else if (act_w == edi_tp_pkg::ACT_EST)
        begin
            if (v == 32'd0)
            begin
                if (!enable_reg || frame_byte[7:2] != wanted_reg)
                    act_w = edi_tp_pkg::ACT_IGNORE;
            end
            else if (v >= 32'd3 && v < nbytes)
            begin
                emit = 1'b1;
                kind = edi_tp_pkg::KIND_STREAM;
                last = (v == nbytes - 32'd1);
            end
        end

        bits_rnd = {1'b0, bits_w} + 33'd7;
        total    = 33'd8 + {3'b000, bits_rnd[32:3]};
        ipos_inc = ipos_reg + 32'd1;
        if (emit && p == plen_next - 32'd1)
            last = 1'b1;

        if (herr_next != 3'(edi_tp_pkg::V_OK))
            code = edi_tp_pkg::verdict_t'(herr_next);
        else if ({1'b0, pos_reg} != end_v + 33'd1)
            code = edi_tp_pkg::V_LEN_ERR;
        else if ((crc_next ^ 16'hFFFF) != {crch_next, frame_byte})
            code = edi_tp_pkg::V_CRC_ERR;
        else
            code = edi_tp_pkg::V_OK;

        pos_next    = (pos_reg == 32'hFFFF_FFFF) ? pos_reg : pos_reg + 32'd1;
        ipos_next   = ipos_reg;
        iname_next  = iname_reg;
        ibits_next  = ibits_reg;
        iflags_next = iflags_reg;
        iact_next   = iact_reg;
        if (walk_en && !skip)
        begin
            ipos_next   = ({1'b0, ipos_inc} >= total) ? 32'd0 : ipos_inc;
            iname_next  = name_w;
            ibits_next  = bits_w;
            iflags_next = flags_w;
            iact_next   = act_w;
        end

        push.valid = 1'b0;
        push.item.kind = kind;
        push.item.data = frame_byte;
        push.item.block_last = last;
        push.item.verdict = edi_tp_pkg::V_OK;
        if (accept)
        begin
            if (frame_last)
            begin
                push.valid = 1'b1;
                push.item.kind = edi_tp_pkg::KIND_VERDICT;
                push.item.data = 8'd0;
                push.item.block_last = 1'b0;
                push.item.verdict = code;
            end
            else
                push.valid = walk_en && !skip && emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 32'd0;
            plen_reg   <= 32'd0;
            crc_reg    <= edi_tp_pkg::CRC_INIT;
            herr_reg   <= 3'd0;
            ipos_reg   <= 32'd0;
            iname_reg  <= 32'd0;
            ibits_reg  <= 32'd0;
            iflags_reg <= 8'd0;
            iact_reg   <= edi_tp_pkg::ACT_IGNORE;
            crch_reg   <= 8'd0;
        end
        else if (accept)
        begin
            if (frame_last)
            begin
                pos_reg    <= 32'd0;
                plen_reg   <= 32'd0;
                crc_reg    <= edi_tp_pkg::CRC_INIT;
                herr_reg   <= 3'd0;
                ipos_reg   <= 32'd0;
                iname_reg  <= 32'd0;
                ibits_reg  <= 32'd0;
                iflags_reg <= 8'd0;
                iact_reg   <= edi_tp_pkg::ACT_IGNORE;
                crch_reg   <= 8'd0;
            end
            else
            begin
                pos_reg    <= pos_next;
                plen_reg   <= plen_next;
                crc_reg    <= crc_next;
                herr_reg   <= herr_next;
                ipos_reg   <= ipos_next;
                iname_reg  <= iname_next;
                ibits_reg  <= ibits_next;
                iflags_reg <= iflags_next;
                iact_reg   <= iact_next;
                crch_reg   <= crch_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wanted_reg <= 6'd0;
            enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == edi_tp_pkg::CFG_WANTED)
                wanted_reg <= cfg_data[5:0];
            else if (cfg_index == edi_tp_pkg::CFG_ENABLE)
                enable_reg <= cfg_data[0];
        end
    end

endmodule

>>> hdl/edi_tp_back.sv
// ----------------------------------------------------------------------------
// EDI AF tag parser back end
// Result queue that decouples the parser from the output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edi_tp_back
#(
    parameter int DEPTH = edi_tp_pkg::QUEUE_DEPTH
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  edi_tp_pkg::push_t       push,
    output edi_tp_pkg::q_status_t   status,
    output logic                    out_valid,
    input  logic                    out_stall,
    output edi_tp_pkg::result_t     out_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    edi_tp_pkg::result_t mem_reg [DEPTH];
    logic [PW-1:0]       wr_reg, wr_next;
    logic [PW-1:0]       rd_reg, rd_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                pop;

    always_comb
    begin
        status.full  = (cnt_reg == FULL_CNT);
        status.empty = (cnt_reg == '0);
        out_valid    = !status.empty;
        out_item     = mem_reg[rd_reg];
        pop          = out_valid && !out_stall;
        wr_next      = push.valid ? ((wr_reg == LAST_PTR) ? '0 : wr_reg + 1'b1) : wr_reg;
        rd_next      = pop ? ((rd_reg == LAST_PTR) ? '0 : rd_reg + 1'b1) : rd_reg;
        cnt_next     = cnt_reg + CW'(push.valid) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            mem_reg[wr_reg] <= push.item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> hdl/edi_af_packet_tag_parser_top.sv
// ----------------------------------------------------------------------------
// EDI AF packet tag parser
// Checks an EDI AF packet, walks its TAG items and passes FIC and stream bytes.
//
// Channel   Handshake            Payload
// in        in_valid / in_stall  frame_byte, frame_last
// out       out_valid/out_stall  out_kind, out_byte, out_block_last, verdict
// cfg       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One byte per cycle while in_stall is low; CRC and decode are combinational.
// Each result is registered in the queue and leaves it when out_stall is low.
// in_stall rises only when the result queue is full; cfg_ready is always high.
// Reset clears all packet state and both registers; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "edi_af_packet_tag_parser_top_defines.svh"

module edi_af_packet_tag_parser_top
#(
    parameter int QUEUE_DEPTH = edi_tp_pkg::QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] frame_byte,
    input  logic       frame_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] out_kind,
    output logic [7:0] out_byte,
    output logic       out_block_last,
    output logic [2:0] verdict,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [7:0] cfg_data
);

    edi_tp_pkg::push_t      push;
    edi_tp_pkg::q_status_t  q_st;
    edi_tp_pkg::result_t    res;
    logic                   accept;

    assign cfg_ready      = 1'b1;
    assign in_stall       = q_st.full;
    assign accept         = in_valid && !in_stall;
    assign out_kind       = res.kind;
    assign out_byte       = res.data;
    assign out_block_last = res.block_last;
    assign verdict        = res.verdict;

    edi_tp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .frame_byte (frame_byte),
        .frame_last (frame_last),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push)
    );

    edi_tp_back #(.DEPTH(QUEUE_DEPTH)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .status    (q_st),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (res)
    );

    `EDI_TP_ASSERT_IMP(a_push_room, push.valid, accept && !q_st.full, "push without room")
    `EDI_TP_ASSERT_IMP(a_verdict_clean, out_valid && out_kind == 2'(edi_tp_pkg::KIND_VERDICT),
        out_byte == 8'd0 && !out_block_last, "verdict carries payload")
    `EDI_TP_ASSERT_IMP(a_byte_clean, out_valid && out_kind != 2'(edi_tp_pkg::KIND_VERDICT),
        verdict == 3'(edi_tp_pkg::V_OK), "payload byte carries verdict")
    `EDI_TP_ASSERT_NEVER(a_empty_valid, q_st.empty && out_valid, "output valid from empty queue")

endmodule

>>> verif/tb_edi_af_packet_tag_parser_top.sv
// ----------------------------------------------------------------------------
// EDI AF tag parser testbench
// Drives EDI AF packets byte by byte through the parser and compares every
// FIC byte, stream byte and frame verdict with a cycle-free behavioral
// predictor. A directed table covers header faults and length errors, then
// random well-formed packets with deti and est items, broken packets and noise.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_edi_af_packet_tag_parser_top;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] frame_byte;
    logic       frame_last;
    logic       out_valid;
    logic       out_stall;
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic       out_block_last;
    logic [2:0] verdict;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_index;
    logic [7:0] cfg_data;

    edi_af_packet_tag_parser_top dut (.*);

    typedef struct {
        logic                  data_;
        logic [7:0]            data;
        logic                  last;
        logic                  has_exp;
        edi_tp_pkg::result_t   exp;
    } stim_row_t;

    edi_tp_pkg::result_t exp_results[$];
    int                  errors;
    int                  got_count;
    logic [7:0]          pkt[$];

    logic [31:0]         p_pos;
    logic [31:0]         p_len;
    logic [15:0]         p_crc;
    logic [2:0]          p_herr;
    logic [31:0]         p_ipos;
    logic [31:0]         p_iname;
    logic [31:0]         p_ibits;
    logic [7:0]          p_iflags;
    edi_tp_pkg::action_t p_act;
    logic [7:0]          p_crc_hi;
    logic [5:0]          p_wanted;
    logic                p_enable;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
            r = r[15] ? ({r[14:0], 1'b0} ^ 16'h1021) : {r[14:0], 1'b0};
        return r;
    endfunction

    task automatic clear_packet();
        p_pos = 0; p_len = 0; p_crc = 16'hFFFF; p_herr = 0; p_ipos = 0;
        p_iname = 0; p_ibits = 0; p_iflags = 0; p_act = edi_tp_pkg::ACT_IGNORE;
        p_crc_hi = 0;
    endtask

    function automatic void flag_header(logic [2:0] code);
        if (p_herr == 0)
            p_herr = code;
    endfunction

    function automatic bit walk_item(logic [7:0] b, logic [31:0] p,
                                     output edi_tp_pkg::kind_t kind, output logic last);
        logic [31:0] o, v, nb, atst, rfud, fic;
        longint total;
        bit emit;
        emit = 0;
        kind = edi_tp_pkg::KIND_FIC;
        last = 0;
        if (p_ipos == 0)
        begin
            if (p_len <= 8 || p >= p_len - 8)
                return 0;
            p_act = edi_tp_pkg::ACT_IGNORE; p_iname = 0; p_ibits = 0; p_iflags = 0;
        end
        o = p_ipos;
        if (o < 4)
            p_iname = {p_iname[23:0], b};
        else if (o < 8)
        begin
            p_ibits = {p_ibits[23:0], b};
            if (o == 7)
            begin
                if (p_iname == edi_tp_pkg::NAME_DETI)
                    p_act = edi_tp_pkg::ACT_DETI;
                else if (p_iname[31:8] == edi_tp_pkg::NAME_EST && p_iname[7:0] >= 1
                         && p_iname[7:0] <= edi_tp_pkg::EST_MAX && p_ibits >= 24)
                    p_act = edi_tp_pkg::ACT_EST;
            end
        end
        else
        begin
            v = o - 8;
            nb = p_ibits / 8;
            if (p_act == edi_tp_pkg::ACT_DETI)
            begin
                atst = p_iflags[7] ? 8 : 0;
                rfud = p_iflags[5] ? 3 : 0;
                if (v == 0)
                    p_iflags = b;
                else if (v == 2)
                begin
                    if (b != edi_tp_pkg::STAT_OK)
                        p_act = edi_tp_pkg::ACT_IGNORE;
                end
                else if (v == 3)
                begin
                    fic = 0;
                    if (p_iflags[6])
                        fic = (b[7:6] == edi_tp_pkg::MODE_3) ? edi_tp_pkg::FIC_LONG
                                                             : edi_tp_pkg::FIC_SHORT;
                    if (fic == 0 || longint'(p_ibits) != (longint'(6 + atst + fic + rfud) * 8))
                        p_act = edi_tp_pkg::ACT_IGNORE;
                end
                else if (v >= 6 + atst && v < nb - rfud)
                begin
                    emit = 1;
                    kind = edi_tp_pkg::KIND_FIC;
                    last = (v == nb - rfud - 1);
                end
            end
            else if (p_act == edi_tp_pkg::ACT_EST)
            begin
                if (v == 0)
                begin
                    if (!p_enable || b[7:2] != p_wanted)
                        p_act = edi_tp_pkg::ACT_IGNORE;
                end
                else if (v >= 3 && v < nb)
                begin
                    emit = 1;
                    kind = edi_tp_pkg::KIND_STREAM;
                    last = (v == nb - 1);
                end
            end
        end
        total = 8 + (longint'(p_ibits) + 7) / 8;
        p_ipos++;
        if (longint'(p_ipos) >= total)
            p_ipos = 0;
        if (emit && p == p_len - 1)
            last = 1;
        return emit;
    endfunction

    task automatic predict_byte(logic [7:0] b, logic fin);
        logic [31:0]         pos;
        longint              stop;
        edi_tp_pkg::kind_t   kind;
        logic                last;
        bit                  got;
        edi_tp_pkg::result_t r;
        logic [2:0]          code;
        pos = p_pos;
        got = 0;
        if (pos < 6)
            p_len = {p_len[23:0], b};
        if (pos == 1)
        begin
            if (p_len[15:0] == edi_tp_pkg::SYNC_PF)
                flag_header(edi_tp_pkg::V_PF);
            else if (p_len[15:0] != edi_tp_pkg::SYNC_AF)
                flag_header(edi_tp_pkg::V_BAD_SYNC);
        end
        else if (pos == 8)
        begin
            if (!b[7])
                flag_header(edi_tp_pkg::V_NO_CRC);
            else if (b[6:4] != edi_tp_pkg::MAJ_VER || b[3:0] != edi_tp_pkg::MIN_VER)
                flag_header(edi_tp_pkg::V_BAD_VER);
        end
        else if (pos == 9 && b != edi_tp_pkg::PT_TAG)
            flag_header(edi_tp_pkg::V_BAD_PT);
        stop = 10 + longint'(p_len);
        if (longint'(pos) < stop)
            p_crc = crc_step(p_crc, b);
        else if (longint'(pos) == stop)
            p_crc_hi = b;
        if (pos >= 10 && longint'(pos) < stop && p_herr == 0)
            got = walk_item(b, pos - 10, kind, last);
        if (fin)
        begin
            if (p_herr != 0)
                code = p_herr;
            else if (longint'(pos) != stop + 1)
                code = edi_tp_pkg::V_LEN_ERR;
            else if ((p_crc ^ 16'hFFFF) != {p_crc_hi, b})
                code = edi_tp_pkg::V_CRC_ERR;
            else
                code = edi_tp_pkg::V_OK;
            clear_packet();
            r.kind = edi_tp_pkg::KIND_VERDICT; r.data = 0; r.block_last = 0;
            r.verdict = edi_tp_pkg::verdict_t'(code);
            exp_results.push_back(r);
            return;
        end
        if (p_pos != 32'hFFFFFFFF)
            p_pos++;
        if (got)
        begin
            r.kind = kind; r.data = b; r.block_last = last; r.verdict = edi_tp_pkg::V_OK;
            exp_results.push_back(r);
        end
    endtask

    task automatic send_byte(logic [7:0] b, logic fin);
        frame_byte <= b;
        frame_last <= fin;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_byte(b, fin);
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 4))
            @(posedge clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [7:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == edi_tp_pkg::CFG_WANTED)
            p_wanted = val[5:0];
        else
            p_enable = val[0];
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (exp_results.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    // build a packet: header, tag items, padding, crc
    task automatic build_packet(int n_items, bit good_crc);
        logic [7:0]  body[$];
        logic [15:0] c;
        int          kind_sel, bits, len, sub;
        logic [7:0]  flags, mid;
        body.delete();
        for (int i = 0; i < n_items; i++)
        begin
            kind_sel = $urandom_range(0, 9);
            if (kind_sel < 3)
            begin
                flags = {$urandom_range(0, 1) == 0, $urandom_range(0, 7) != 0,
                         $urandom_range(0, 1) == 0, 5'($urandom)};
                mid = {($urandom_range(0, 1) ? 2'd3 : 2'($urandom)), 6'($urandom)};
                len = 6 + (flags[7] ? 8 : 0) + (mid[7:6] == 3 ? 128 : 96)
                      + (flags[5] ? 3 : 0);
                if ($urandom_range(0, 7) == 0)
                    len = len + $urandom_range(0, 2) - 1;
                bits = len * 8;
                body.push_back("d"); body.push_back("e");
                body.push_back("t"); body.push_back("i");
                for (int k = 3; k >= 0; k--)
                    body.push_back(8'(bits >> (8 * k)));
                for (int k = 0; k < len; k++)
                begin
                    if (k == 0)
                        body.push_back(flags);
                    else if (k == 2)
                        body.push_back($urandom_range(0, 7) ? edi_tp_pkg::STAT_OK
                                                            : 8'($urandom));
                    else if (k == 3)
                        body.push_back(mid);
                    else
                        body.push_back(8'($urandom));
                end
            end
            else if (kind_sel < 8)
            begin
                bits = $urandom_range(0, 3) ? $urandom_range(3, 40) * 8
                                            : $urandom_range(20, 330);
                sub = $urandom_range(0, 1) ? p_wanted : $urandom_range(0, 63);
                body.push_back("e"); body.push_back("s"); body.push_back("t");
                body.push_back($urandom_range(0, 9) ? 8'($urandom_range(1, 64))
                                                    : 8'($urandom_range(0, 1) ? 0 : 65));
                for (int k = 3; k >= 0; k--)
                    body.push_back(8'(bits >> (8 * k)));
                for (int k = 0; k < (bits + 7) / 8; k++)
                    body.push_back(k == 0 ? {6'(sub), 2'($urandom)} : 8'($urandom));
            end
            else
            begin
                bits = $urandom_range(0, 80);
                for (int k = 0; k < 4; k++)
                    body.push_back(8'($urandom));
                for (int k = 3; k >= 0; k--)
                    body.push_back(8'(bits >> (8 * k)));
                for (int k = 0; k < (bits + 7) / 8; k++)
                    body.push_back(8'($urandom));
            end
        end
        repeat ($urandom_range(0, 3))
            body.push_back(8'($urandom));
        if (body.size() > 8 && $urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 8))
                void'(body.pop_back());
        pkt.delete();
        pkt.push_back("A"); pkt.push_back("F");
        for (int k = 3; k >= 0; k--)
            pkt.push_back(8'(body.size() >> (8 * k)));
        pkt.push_back(8'($urandom)); pkt.push_back(8'($urandom));
        pkt.push_back(8'h90); pkt.push_back(edi_tp_pkg::PT_TAG);
        foreach (body[k])
            pkt.push_back(body[k]);
        c = 16'hFFFF;
        foreach (pkt[k])
            c = crc_step(c, pkt[k]);
        c = ~c;
        if (!good_crc)
            c[$urandom_range(0, 15)] ^= 1'b1;
        pkt.push_back(c[15:8]);
        pkt.push_back(c[7:0]);
    endtask

    task automatic send_packet(int burst_mode);
        int burst;
        burst = $urandom_range(1, 40);
        foreach (pkt[k])
        begin
            send_byte(pkt[k], k == pkt.size() - 1);
            if (burst_mode != 0 && --burst == 0)
            begin
                drop_valid();
                burst = $urandom_range(1, 40);
            end
        end
    endtask

    // receiver: stall pattern cycles through quiet, light random and heavy random phases
    int stall_phase;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            stall_phase <= (stall_phase + 1) % 300;
            if (stall_phase < 100)
                out_stall <= 1'b0;
            else if (stall_phase < 200)
                out_stall <= ($urandom_range(0, 3) == 0);
            else
                out_stall <= ($urandom_range(0, 1) == 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got_count++;
            if (exp_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result kind=%0d byte=%02h last=%0b verdict=%0d",
                         $realtime, out_kind, out_byte, out_block_last, verdict);
            end
            else
            begin
                edi_tp_pkg::result_t e;
                e = exp_results.pop_front();
                if (out_kind !== e.kind || out_byte !== e.data
                    || out_block_last !== e.block_last || verdict !== e.verdict)
                begin
                    errors++;
                    $display("%0t: mismatch exp kind=%0d byte=%02h last=%0b verdict=%0d",
                             $realtime, e.kind, e.data, e.block_last, e.verdict);
                    $display("%0t:          act kind=%0d byte=%02h last=%0b verdict=%0d",
                             $realtime, out_kind, out_byte, out_block_last, verdict);
                end
            end
        end
    end

    stim_row_t dir_table[$];

    task automatic add_row(logic [7:0] d, logic l, bit he, edi_tp_pkg::verdict_t v);
        stim_row_t r;
        r.data_ = 1'b0;
        r.data = d; r.last = l; r.has_exp = he;
        r.exp.kind = edi_tp_pkg::KIND_VERDICT; r.exp.data = 0; r.exp.block_last = 0;
        r.exp.verdict = v;
        dir_table.push_back(r);
    endtask

    initial
    begin
        int sent;
        errors = 0;
        got_count = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        frame_byte = 8'h00;
        frame_last = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = 8'h00;
        cfg_data = 8'h00;
        p_wanted = 0;
        p_enable = 0;
        clear_packet();
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-byte and short packets, then header faults
        add_row(8'hFF, 1'b1, 1, edi_tp_pkg::V_LEN_ERR);
        add_row(8'h00, 1'b1, 1, edi_tp_pkg::V_LEN_ERR);
        add_row("P", 1'b0, 0, edi_tp_pkg::V_OK);
        add_row("F", 1'b1, 1, edi_tp_pkg::V_PF);
        add_row("A", 1'b0, 0, edi_tp_pkg::V_OK);
        add_row("F", 1'b1, 1, edi_tp_pkg::V_LEN_ERR);
        for (int k = 0; k < 10; k++)
            add_row(k == 0 ? "A" : k == 1 ? "F" : k == 8 ? 8'h10 : 8'h00,
                    k == 9, k == 9, edi_tp_pkg::V_NO_CRC);
        for (int k = 0; k < 10; k++)
            add_row(k == 0 ? "A" : k == 1 ? "F" : k == 8 ? 8'hFF : 8'h00,
                    k == 9, k == 9, edi_tp_pkg::V_BAD_VER);
        foreach (dir_table[i])
        begin
            send_byte(dir_table[i].data, dir_table[i].last);
            if (dir_table[i].has_exp && exp_results.size() != 0
                && exp_results[$] != dir_table[i].exp)
            begin
                errors++;
                $display("%0t: table row %0d exp verdict=%0d predictor=%0d",
                         $realtime, i, dir_table[i].exp.verdict, exp_results[$].verdict);
            end
        end
        drain();

        write_reg(edi_tp_pkg::CFG_WANTED, 8'd63);
        write_reg(edi_tp_pkg::CFG_ENABLE, 8'd1);
        build_packet(3, 1);
        send_packet(0);
        build_packet(2, 0);
        send_packet(0);
        drain();
        write_reg(edi_tp_pkg::CFG_WANTED, 8'd0);

        sent = 0;
        while (sent < 1700)
        begin
            if (sent > 1000 && $urandom_range(0, 3) == 0)
            begin
                drain();
                write_reg(edi_tp_pkg::CFG_WANTED, 8'($urandom_range(0, 63)));
                write_reg(edi_tp_pkg::CFG_ENABLE, 8'($urandom_range(0, 3) != 0));
            end
            if ($urandom_range(0, 9) == 0)
            begin
                pkt.delete();
                repeat ($urandom_range(1, 20))
                    pkt.push_back(8'($urandom));
                if ($urandom_range(0, 1))
                begin
                    pkt[0] = "A";
                    if (pkt.size() > 1)
                        pkt[1] = "F";
                end
            end
            else
            begin
                build_packet($urandom_range(1, 3), $urandom_range(0, 7) != 0);
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(1, 3))
                        pkt.push_back(8'($urandom));
            end
            sent += pkt.size();
            send_packet($urandom_range(0, 2));
            if ($urandom_range(0, 19) == 0)
                drain();
        end

        in_valid <= 1'b0;
        while (exp_results.size() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);
        if (errors == 0 && exp_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
